[src/col_pkg.sv]
// Shared types and constants for the cursor ordered list.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package col_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int REQ_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    // Request codes; 6 and 7 behave as a query
    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 3'd0,
        REQ_ADVANCE = 3'd1,
        REQ_INSERT  = 3'd2,
        REQ_ATTACH  = 3'd3,
        REQ_REMOVE  = 3'd4,
        REQ_QUERY   = 3'd5
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOCUR = 2'd2
    } status_t;

    // Operation broadcast to the cell row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    // Per-request update from the controller
    typedef struct packed {
        cell_op_t op;
        status_t  status;
    } list_upd_t;

endpackage

[src/col_cell.sv]
// One storage cell of the list: holds a single entry and shifts with its neighbors.
// Depends on col_pkg (cell_op_t).
`timescale 1ns / 1ps

module col_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  col_pkg::cell_op_t     op,
    input  logic [POS_W-1:0]      pos,
    input  logic [DATA_WIDTH-1:0] new_value,
    input  logic [DATA_WIDTH-1:0] left_value,
    input  logic [DATA_WIDTH-1:0] right_value,
    output logic [DATA_WIDTH-1:0] value
);
    import col_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Pick own value, the new entry, or a neighbor's value
    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                if (MY_POS == pos)
                begin
                    data_next = new_value;
                end
                else if (MY_POS > pos)
                begin
                    data_next = left_value;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_POS >= pos)
                begin
                    data_next = right_value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign value = data_reg;

endmodule

[src/col_ctrl.sv]
// Cursor and count control for the list: decodes requests and drives the cell row.
// Depends on col_pkg (req_t, status_t, cell_op_t, list_upd_t).
`timescale 1ns / 1ps

module col_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CW       = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [col_pkg::REQ_W-1:0] req,
    output col_pkg::list_upd_t      upd,
    output logic [CW-1:0]           pos,
    output logic [CW-1:0]           cursor,
    output logic [CW-1:0]           count
);
    import col_pkg::*;

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [CW-1:0] cursor_reg;
    logic [CW-1:0] cursor_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          at_item;
    logic          full;

    assign at_item = cursor_reg < count_reg;
    assign full    = count_reg == FULL_COUNT;

    // Request decode
    always_comb
    begin
        upd.op      = CELL_HOLD;
        upd.status  = ST_OK;
        pos         = cursor_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        if (accept)
        begin
            unique case (req_t'(req))
                REQ_START:
                begin
                    cursor_next = '0;
                end
                REQ_ADVANCE:
                begin
                    if (at_item)
                    begin
                        cursor_next = cursor_reg + 1'b1;
                    end
                    else
                    begin
                        upd.status = ST_NOCUR;
                    end
                end
                REQ_INSERT:
                begin
                    if (full)
                    begin
                        upd.status = ST_FULL;
                    end
                    else
                    begin
                        upd.op      = CELL_INSERT;
                        pos         = at_item ? cursor_reg : '0;
                        cursor_next = at_item ? cursor_reg : '0;
                        count_next  = count_reg + 1'b1;
                    end
                end
                REQ_ATTACH:
                begin
                    if (full)
                    begin
                        upd.status = ST_FULL;
                    end
                    else
                    begin
                        // empty list lands at 0 since count is 0 there
                        upd.op      = CELL_INSERT;
                        pos         = at_item ? cursor_reg + 1'b1 : count_reg;
                        cursor_next = at_item ? cursor_reg + 1'b1 : count_reg;
                        count_next  = count_reg + 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    if (at_item)
                    begin
                        upd.op     = CELL_REMOVE;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        upd.status = ST_NOCUR;
                    end
                end
                default:
                begin
                    upd.status = ST_OK;
                end
            endcase
        end
    end

    // Cursor and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
        end
    end

    assign cursor = cursor_reg;
    assign count  = count_reg;

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond item count");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("item count beyond capacity");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && upd.status == ST_FULL) |=> $stable(count_reg) && $stable(cursor_reg))
        else $error("refused insert changed the list");

    a_remove_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && upd.op == CELL_REMOVE) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not drop the count");
`endif

endmodule

[src/cursor_ordered_list.sv]
// Top level of the cursor ordered list: controller, row of cells, result register.
// Depends on col_pkg, col_ctrl and col_cell.
`timescale 1ns / 1ps
//
//  channel | beat fields                                        | handshake
//  --------+----------------------------------------------------+----------------------
//  in      | req_type, entry_value                              | in_valid / in_ready
//  out     | has_current, current_value, item_count, status     | out_valid / out_ready
//
//  One request per cycle while in_ready holds: cells from pos onward shift when accepted.
//  The list updates at the accepting edge; the result beat is valid on the next cycle.
//  A result waiting in the output register takes in_ready low until out_ready frees it.
//  Reset clears count and cursor; entries stay undefined until written.

module cursor_ordered_list #(
    parameter int CAPACITY   = col_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = col_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [col_pkg::REQ_W-1:0]     req_type,
    input  logic [col_pkg::VALUE_W-1:0]   entry_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          has_current,
    output logic [col_pkg::VALUE_W-1:0]   current_value,
    output logic [col_pkg::COUNT_OUT_W-1:0] item_count,
    output logic [col_pkg::STATUS_W-1:0]  status
);
    import col_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic                  accept;
    list_upd_t             upd;
    logic [CW-1:0]         pos;
    logic [CW-1:0]         cursor;
    logic [CW-1:0]         count;
    logic [DATA_WIDTH-1:0] new_value;
    logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
    logic                  at_item;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               status_reg;

    // Input handshake
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign new_value = DATA_WIDTH'(entry_value);

    col_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req_type),
        .upd    (upd),
        .pos    (pos),
        .cursor (cursor),
        .count  (count)
    );

    // Row of cells, each linked to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_value;
        logic [DATA_WIDTH-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = cell_value[i];
        end
        else
        begin : g_left
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_right
            assign right_value = cell_value[i+1];
        end

        col_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS_W      (CW),
            .INDEX      (i)
        ) u_cell (
            .clk         (clk),
            .op          (upd.op),
            .pos         (pos),
            .new_value   (new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i])
        );
    end

    // Output beat valid and status
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= upd.status;
        end
    end

    // List state is frozen while a result waits, so read it directly
    assign at_item       = cursor < count;
    assign out_valid     = out_valid_reg;
    assign has_current   = at_item;
    assign current_value = at_item ? VALUE_W'(cell_value[cursor[IW-1:0]]) : '0;
    assign item_count    = COUNT_OUT_W'(count);
    assign status        = status_reg;

endmodule
